FILE: sv/hexl_pkg.sv
// ----------------------------------------------------------------------------
// hexl_pkg
// Shared types, codes and sizing for the hex record loader.
// ----------------------------------------------------------------------------
package hexl_pkg;

  // Image size in bytes; addresses at or above it are rejected.
  localparam int IMAGE_SIZE = 65536;

  // Written map geometry: one bit per image byte, packed into rows.
  localparam int MAP_ROW_W  = 32;
  localparam int MAP_COL_AW = $clog2(MAP_ROW_W);
  localparam int MAP_ROWS   = (IMAGE_SIZE + MAP_ROW_W - 1) / MAP_ROW_W;
  localparam int MAP_ROW_AW = $clog2(MAP_ROWS);

  localparam logic [16:0] IMAGE_LIMIT = 17'(IMAGE_SIZE);
  localparam logic [7:0]  COLON       = 8'h3A;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Error codes; ERR_NONE shares its value with ERR_LEN_DIGIT, which is
  // never held as a pending code.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_LEN_DIGIT   = 3'd0;
  localparam logic [2:0] ERR_ADDR_DIGIT  = 3'd1;
  localparam logic [2:0] ERR_TYPE_DIGIT  = 3'd2;
  localparam logic [2:0] ERR_DATA_DIGIT  = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM    = 3'd4;
  localparam logic [2:0] ERR_BEYOND      = 3'd5;
  localparam logic [2:0] ERR_OVERLAP     = 3'd6;
  localparam logic [2:0] ERR_NO_END      = 3'd7;

  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;

  typedef enum logic [6:0] {
    PH_SEEK    = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_ADDR_HI = 7'b0000100,
    PH_ADDR_LO = 7'b0001000,
    PH_TYPE    = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_CSUM    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [2:0]  err;
  } result_t;

  // Parser -> map: address whose bit is looked up, and a set strobe.
  typedef struct packed {
    logic        set;
    logic [15:0] addr;
  } map_req_t;

  // Map -> parser/top
  typedef struct packed {
    logic busy;
    logic hit;
  } map_stat_t;

  // Bit 4 flags a non-hex character.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) n = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) n = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) n = 5'(c - 8'h57);
    return n;
  endfunction

endpackage

FILE: sv/hexl_ram.sv
// ----------------------------------------------------------------------------
// hexl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hexl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/hexl_map.sv
// ----------------------------------------------------------------------------
// hexl_map
// Written-byte map: bit-per-byte RAM, cleared row by row after reset.
// ----------------------------------------------------------------------------
module hexl_map (
  input  logic                clk,
  input  logic                rst,
  input  hexl_pkg::map_req_t  req,
  output hexl_pkg::map_stat_t stat
);

  logic                            clearing;
  logic [hexl_pkg::MAP_ROW_AW-1:0] clr_cnt;
  logic [15:0]                     row_shift;
  logic [hexl_pkg::MAP_ROW_AW-1:0] row;
  logic [hexl_pkg::MAP_COL_AW-1:0] col;
  logic [hexl_pkg::MAP_ROW_W-1:0]  rd_row;
  logic                            wr_en;
  logic [hexl_pkg::MAP_ROW_AW-1:0] wr_addr;
  logic [hexl_pkg::MAP_ROW_W-1:0]  wr_data;

  assign row_shift = req.addr >> hexl_pkg::MAP_COL_AW;
  assign row       = row_shift[hexl_pkg::MAP_ROW_AW-1:0];
  assign col       = req.addr[hexl_pkg::MAP_COL_AW-1:0];

  // The lookup address is held steady before a set, so rd_row already
  // holds the row being modified.
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = req.set;
      wr_addr = row;
      wr_data = rd_row | (hexl_pkg::MAP_ROW_W'(1) << col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == hexl_pkg::MAP_ROW_AW'(hexl_pkg::MAP_ROWS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  hexl_ram #(
    .WIDTH (hexl_pkg::MAP_ROW_W),
    .DEPTH (hexl_pkg::MAP_ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (row),
    .rd_data (rd_row)
  );

  assign stat.busy = clearing;
  assign stat.hit  = rd_row[col];

endmodule

FILE: sv/hexl_parser.sv
// ----------------------------------------------------------------------------
// hexl_parser
// Record field decoder: one character per transfer, one result at most.
// ----------------------------------------------------------------------------
module hexl_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          char_code,
  input  logic                end_of_file,
  input  hexl_pkg::map_stat_t map_stat,
  output hexl_pkg::map_req_t  map_req,
  output hexl_pkg::result_t   res
);

  hexl_pkg::phase_t phase, phase_next;
  logic [4:0]  high_nibble, high_nibble_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [2:0]  pending_error, pending_error_next;
  logic        load_over, load_over_next;

  logic [4:0]  nib;
  logic [3:0]  digit;
  logic [7:0]  byte_val;
  logic [7:0]  sum_upd;
  logic [7:0]  bytes_inc;
  logic [16:0] addr_sum;
  logic [2:0]  pend;
  logic        in_header;

  assign nib       = hexl_pkg::nibble_of(char_code);
  assign digit     = nib[4] ? 4'hF : nib[3:0];
  assign byte_val  = {high_nibble[3:0], digit};
  assign sum_upd   = running_sum + byte_val;
  assign bytes_inc = bytes_seen + 8'd1;
  assign addr_sum  = {1'b0, record_address} + {9'd0, bytes_seen};
  assign in_header = (phase == hexl_pkg::PH_LEN) || (phase == hexl_pkg::PH_ADDR_HI) ||
                     (phase == hexl_pkg::PH_ADDR_LO) || (phase == hexl_pkg::PH_TYPE);

  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    record_length_next  = record_length;
    record_address_next = record_address;
    record_type_next    = record_type;
    running_sum_next    = running_sum;
    bytes_seen_next     = bytes_seen;
    pending_error_next  = pending_error;
    load_over_next      = load_over;
    pend                = pending_error;
    res                 = '0;
    map_req.set         = 1'b0;
    map_req.addr        = addr_sum[15:0];

    if (fire && !load_over) begin
      if (phase == hexl_pkg::PH_SEEK) begin
        if (char_code == hexl_pkg::COLON) begin
          phase_next          = hexl_pkg::PH_LEN;
          high_nibble_next    = '0;
          record_length_next  = '0;
          record_address_next = '0;
          record_type_next    = '0;
          running_sum_next    = '0;
          bytes_seen_next     = '0;
          pending_error_next  = hexl_pkg::ERR_NONE;
        end
      end else if (nib[4] && in_header) begin
        // bad digit in a header field fails the load at once
        res.valid = 1'b1;
        res.kind  = hexl_pkg::KIND_FAIL;
        if (phase == hexl_pkg::PH_LEN) res.err = hexl_pkg::ERR_LEN_DIGIT;
        else if (phase == hexl_pkg::PH_TYPE) res.err = hexl_pkg::ERR_TYPE_DIGIT;
        else res.err = hexl_pkg::ERR_ADDR_DIGIT;
        load_over_next = 1'b1;
      end else begin
        if (nib[4]) begin
          if (phase == hexl_pkg::PH_CSUM) pend = hexl_pkg::ERR_CHECKSUM;
          else if (pend == hexl_pkg::ERR_NONE) pend = hexl_pkg::ERR_DATA_DIGIT;
        end
        if (!high_nibble[4]) begin
          high_nibble_next = {1'b1, digit};
        end else begin
          high_nibble_next = '0;
          running_sum_next = sum_upd;
          unique case (phase)
            hexl_pkg::PH_LEN: begin
              record_length_next = byte_val;
              phase_next         = hexl_pkg::PH_ADDR_HI;
            end
            hexl_pkg::PH_ADDR_HI: begin
              record_address_next = {byte_val, 8'd0};
              phase_next          = hexl_pkg::PH_ADDR_LO;
            end
            hexl_pkg::PH_ADDR_LO: begin
              record_address_next = {record_address[15:8], byte_val};
              phase_next          = hexl_pkg::PH_TYPE;
            end
            hexl_pkg::PH_TYPE: begin
              record_type_next = byte_val;
              phase_next = (record_length != 8'd0) ? hexl_pkg::PH_DATA : hexl_pkg::PH_CSUM;
            end
            hexl_pkg::PH_DATA: begin
              if (record_type == hexl_pkg::REC_DATA && pend == hexl_pkg::ERR_NONE) begin
                if (addr_sum >= hexl_pkg::IMAGE_LIMIT) begin
                  pend = hexl_pkg::ERR_BEYOND;
                end else if (map_stat.hit) begin
                  pend = hexl_pkg::ERR_OVERLAP;
                end else begin
                  map_req.set = 1'b1;
                  res.valid   = 1'b1;
                  res.kind    = hexl_pkg::KIND_DATA;
                  res.addr    = addr_sum[15:0];
                  res.value   = byte_val;
                end
              end
              bytes_seen_next = bytes_inc;
              if (bytes_inc == record_length) phase_next = hexl_pkg::PH_CSUM;
            end
            hexl_pkg::PH_CSUM: begin
              phase_next = hexl_pkg::PH_SEEK;
              if (pend == hexl_pkg::ERR_CHECKSUM || sum_upd != 8'd0) begin
                res.valid      = 1'b1;
                res.kind       = hexl_pkg::KIND_FAIL;
                res.err        = hexl_pkg::ERR_CHECKSUM;
                load_over_next = 1'b1;
              end else if (pend != hexl_pkg::ERR_NONE) begin
                res.valid      = 1'b1;
                res.kind       = hexl_pkg::KIND_FAIL;
                res.err        = pend;
                load_over_next = 1'b1;
              end else if (record_type == hexl_pkg::REC_EOF) begin
                res.valid      = 1'b1;
                res.kind       = hexl_pkg::KIND_OK;
                load_over_next = 1'b1;
              end
            end
            default: begin
              phase_next = hexl_pkg::PH_SEEK;
            end
          endcase
        end
        pending_error_next = pend;
      end

      // file ended without a verdict: this overrides any data byte
      if (end_of_file && !load_over_next) begin
        res            = '0;
        res.valid      = 1'b1;
        res.kind       = hexl_pkg::KIND_FAIL;
        res.err        = hexl_pkg::ERR_NO_END;
        load_over_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hexl_pkg::PH_SEEK;
      high_nibble    <= '0;
      record_length  <= '0;
      record_address <= '0;
      record_type    <= '0;
      running_sum    <= '0;
      bytes_seen     <= '0;
      pending_error  <= hexl_pkg::ERR_NONE;
      load_over      <= 1'b0;
    end else begin
      phase          <= phase_next;
      high_nibble    <= high_nibble_next;
      record_length  <= record_length_next;
      record_address <= record_address_next;
      record_type    <= record_type_next;
      running_sum    <= running_sum_next;
      bytes_seen     <= bytes_seen_next;
      pending_error  <= pending_error_next;
      load_over      <= load_over_next;
    end
  end

endmodule

FILE: sv/intel_hex_record_loader_core.sv
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core
// Result path: a result is formed from the transferred character that
//   causes it and is registered in the output register or the skid entry.
// Throughput: 1 character per cycle while in_stall is low, set by the
//   single-pass decoder and one written-map read-modify-write per data byte.
// Reset: synchronous; the written map is then cleared one 32-bit row per
//   cycle (MAP_ROWS = 2048 rows), with in_stall high until it is done.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_core (
  input  logic        clk,
  input  logic        rst,
  // character input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_file,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] byte_address,
  output logic [7:0]  byte_value,
  output logic [2:0]  error_code
);

  hexl_pkg::map_req_t  map_req;
  hexl_pkg::map_stat_t map_stat;
  hexl_pkg::result_t   res;
  hexl_pkg::result_t   skid;
  logic                skid_valid;
  logic                fire;
  logic                out_free;

  // A transfer happens only when the skid slot is empty, so a new result
  // always has somewhere to go even if the output register is held.
  assign in_stall = skid_valid | map_stat.busy;
  assign fire     = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  hexl_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .char_code   (char_code),
    .end_of_file (end_of_file),
    .map_stat    (map_stat),
    .map_req     (map_req),
    .res         (res)
  );

  hexl_map u_map (
    .clk  (clk),
    .rst  (rst),
    .req  (map_req),
    .stat (map_stat)
  );

  // Output register plus one-entry skid. While the skid holds a result the
  // input is stalled, so res.valid cannot collide with a skid drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        kind         <= skid.kind;
        byte_address <= skid.addr;
        byte_value   <= skid.value;
        error_code   <= skid.err;
      end else begin
        kind         <= res.kind;
        byte_address <= res.addr;
        byte_value   <= res.value;
        error_code   <= res.err;
      end
    end else if (res.valid) begin
      skid <= res;
    end
  end

endmodule

FILE: sv/hexl_checker.sv
// ----------------------------------------------------------------------------
// hexl_checker
// Port-level checks on the loader's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hexl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [15:0] byte_address,
  input logic [7:0]  byte_value,
  input logic [2:0]  error_code
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(byte_address) &&
                               $stable(byte_value) && $stable(error_code))
    else $error("result changed while stalled");

  // a final verdict is the last result of the load
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind != hexl_pkg::KIND_DATA |=> !out_valid)
    else $error("result after final verdict");

  a_data_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hexl_pkg::KIND_DATA |-> error_code == hexl_pkg::ERR_NONE)
    else $error("data byte carries an error code");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != hexl_pkg::KIND_DATA |-> byte_address == 16'd0 && byte_value == 8'd0
                                                 && kind != 2'd3)
    else $error("verdict with stray payload");

  // right after reset the map clear holds off input
  a_reset_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall && !out_valid)
    else $error("input open during map clear");

endmodule

bind intel_hex_record_loader_core hexl_checker u_hexl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .byte_address (byte_address),
  .byte_value   (byte_value),
  .error_code   (error_code)
);
